// ===== hw/rtl/amad_pkg.sv =====
// shared types and constants of the analog moving average deadband filter
package amad_pkg;

	// sizing of the filter
	localparam int CHANNELS   = 8;
	localparam int WINDOW     = 8;
	localparam int FULL_SCALE = 1023;

	// field widths
	localparam int CH_W  = 3;
	localparam int VAL_W = 10;

	// derived widths
	localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int ADDR_W  = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;
	localparam int SUM_W   = $clog2(FULL_SCALE * WINDOW + 1);
	localparam int NUM_W   = $clog2(2 * FULL_SCALE * WINDOW + WINDOW + 1);
	localparam int MEAN_DIV = 2 * WINDOW;

	// item modes
	localparam logic MODE_PRIME  = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	// one input beat
	typedef struct packed {
		logic             mode;
		logic [CH_W-1:0]  channel;
		logic [VAL_W-1:0] sample;
		logic             suppress_event;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [CH_W-1:0]  out_channel;
		logic [VAL_W-1:0] value;
	} result_t;

endpackage

// ===== hw/rtl/analog_moving_average_deadband.sv =====
// Top level of the analog moving average deadband filter.
//
// One item is taken every clock cycle while item_stall is low. An accepted beat inverts its
// sample, looks up and advances its channel's ring position and starts the read of the ring
// slot it replaces; in the next stage the running sum is updated, the rounded mean is compared
// with the last report and the slot is written back. A change passes from the stage one
// registers through the output register to the result port. The single ring memory (one read
// and one write port, registered read) sets this two-stage shape; a back-to-back item that
// reads the slot just being written gets the new value by forwarding. Priming a channel needs
// no pass over the ring: the whole window is marked as holding the primed value until the ring
// position wraps. No clearing pass is needed after reset. item_stall rises only while a result
// waits in the output register and the next result is ready behind it.
module analog_moving_average_deadband
	import amad_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// per channel state
	logic [SUM_W-1:0] sum_q       [CHANNELS];
	logic [VAL_W-1:0] rep_q       [CHANNELS];
	logic [POS_W-1:0] pos_q       [CHANNELS];
	logic [VAL_W-1:0] prime_val_q [CHANNELS];
	logic             full_q      [CHANNELS];

	// ring memory
	logic [VAL_W-1:0] win_mem [CHANNELS*WINDOW];

	// stage one
	logic             valid_s1;
	logic             mode_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [POS_W-1:0] pos_s1;
	logic [VAL_W-1:0] inv_s1;
	logic             quiet_s1;
	logic             use_mem_s1;
	logic [VAL_W-1:0] alt_s1;
	logic [VAL_W-1:0] rd_s1;

	// output register
	logic    result_valid_q;
	result_t result_q;

	// handshake
	logic accept;
	logic out_free;
	logic emit;
	logic move;

	// front end
	logic [VAL_W-1:0]  inv;
	logic [POS_W-1:0]  pos_rd;
	logic [POS_W-1:0]  pos_nxt;
	logic              wrap;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              fwd;

	// back end
	logic [VAL_W-1:0] old_entry;
	logic [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0] sum_prime;
	logic [NUM_W-1:0] mean_num;
	logic [VAL_W-1:0] mean;
	logic [VAL_W-1:0] rep_old;
	logic [VAL_W-1:0] diff;
	logic             change;
	logic [VAL_W-1:0] snapped;

	// flow control
	assign out_free   = ~result_valid_q | ~result_stall;
	assign emit       = valid_s1 & (mode_s1 == MODE_UPDATE) & change & ~quiet_s1;
	assign move       = valid_s1 & (~emit | out_free);
	assign item_stall = valid_s1 & ~move;
	assign accept     = item_valid & ~item_stall;

	// inversion, ring position and read address
	always_comb begin
		if (item.sample > VAL_W'(FULL_SCALE)) begin
			inv = '0;
		end else begin
			inv = VAL_W'(FULL_SCALE) - item.sample;
		end
		pos_rd  = pos_q[item.channel];
		wrap    = (pos_rd == POS_W'(WINDOW - 1));
		pos_nxt = wrap ? '0 : pos_rd + POS_W'(1);
		rd_addr = ADDR_W'(item.channel) * ADDR_W'(WINDOW) + ADDR_W'(pos_rd);
		wr_addr = ADDR_W'(ch_s1) * ADDR_W'(WINDOW) + ADDR_W'(pos_s1);
		fwd     = valid_s1 & (mode_s1 == MODE_UPDATE) & (ch_s1 == item.channel)
			& (pos_s1 == pos_rd);
	end

	// ring position, fill flag and primed value, kept at the front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]       <= '0;
				full_q[i]      <= 1'b0;
				prime_val_q[i] <= '0;
			end
		end else if (accept) begin
			if (item.mode == MODE_PRIME) begin
				pos_q[item.channel]       <= '0;
				full_q[item.channel]      <= 1'b0;
				prime_val_q[item.channel] <= inv;
			end else begin
				pos_q[item.channel] <= pos_nxt;
				if (wrap) begin
					full_q[item.channel] <= 1'b1;
				end
			end
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= item.mode;
			ch_s1      <= item.channel;
			pos_s1     <= pos_rd;
			inv_s1     <= inv;
			quiet_s1   <= item.suppress_event;
			use_mem_s1 <= full_q[item.channel] & ~fwd;
			alt_s1     <= fwd ? inv_s1 : prime_val_q[item.channel];
		end
	end

	// ring memory, registered read and write back of the new entry
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= win_mem[rd_addr];
		end
		if (move && (mode_s1 == MODE_UPDATE)) begin
			win_mem[wr_addr] <= inv_s1;
		end
	end

	// running sum, rounded mean and deadband test
	always_comb begin
		old_entry = use_mem_s1 ? rd_s1 : alt_s1;
		sum_new   = sum_q[ch_s1] - SUM_W'(old_entry) + SUM_W'(inv_s1);
		sum_prime = SUM_W'(inv_s1) * SUM_W'(WINDOW);
		mean_num  = NUM_W'({sum_new, 1'b0}) + NUM_W'(WINDOW);
		mean      = VAL_W'(mean_num / MEAN_DIV);
		rep_old   = rep_q[ch_s1];
		diff      = (mean > rep_old) ? (mean - rep_old) : (rep_old - mean);
		change    = (diff > VAL_W'(1));
		if (mean < VAL_W'(2)) begin
			snapped = '0;
		end else if (mean > VAL_W'(FULL_SCALE - 2)) begin
			snapped = VAL_W'(FULL_SCALE);
		end else begin
			snapped = mean;
		end
	end

	// sum and report, kept at the back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i] <= '0;
				rep_q[i] <= '0;
			end
		end else if (move) begin
			if (mode_s1 == MODE_PRIME) begin
				sum_q[ch_s1] <= sum_prime;
				rep_q[ch_s1] <= '0;
			end else begin
				sum_q[ch_s1] <= sum_new;
				if (change) begin
					rep_q[ch_s1] <= snapped;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			result_q.out_channel <= ch_s1;
			result_q.value       <= snapped;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a stall toward the source only while both result slots are taken
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("item stall without a full back end");

	// a prime beat never produces a result
	a_prime_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (mode_s1 == MODE_PRIME)) |-> !emit)
		else $error("prime beat raised a result");

	// reported values are snapped at both ends
	a_snap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> ((result_q.value == '0 || result_q.value >= VAL_W'(2))
			&& (result_q.value <= VAL_W'(FULL_SCALE - 2)
			|| result_q.value == VAL_W'(FULL_SCALE))))
		else $error("result value not snapped");

	// a result that is held back stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> (result_valid_q && $stable(result_q)))
		else $error("held result changed");

	// ring position stays inside the window
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (pos_rd <= POS_W'(WINDOW - 1)))
		else $error("ring position out of range");

endmodule

// ===== tb/tb_analog_moving_average_deadband.sv =====
// self-checking testbench for the analog moving average deadband filter
`timescale 1ns / 1ps

module tb_analog_moving_average_deadband;
	import amad_pkg::*;

	localparam int RANDOM_BEATS = 626;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 100000;

	// one row of the directed plan; given marks an outcome written in by hand
	typedef struct packed {
		logic             mode;
		logic [CH_W-1:0]  channel;
		logic [VAL_W-1:0] sample;
		logic             quiet;
		logic             given;
		logic             fires;
		logic [CH_W-1:0]  want_channel;
		logic [VAL_W-1:0] want_value;
	} plan_row_t;

	localparam int PLAN_ROWS = 24;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// full inverted scale on channel 0
		'{MODE_PRIME,  3'd0, 10'd0,    1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd0, 10'd0,    1'b0, 1'b1, 1'b1, 3'd0, 10'd1023},
		'{MODE_UPDATE, 3'd0, 10'd0,    1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		// zero inverted scale, prime with suppress set
		'{MODE_PRIME,  3'd1, 10'd1023, 1'b1, 1'b1, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd1, 10'd1023, 1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		// suppressed change then a visible one
		'{MODE_PRIME,  3'd2, 10'd1023, 1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd2, 10'd0,    1'b1, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd2, 10'd0,    1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		// deadband: a step of one is held, a step of two goes out
		'{MODE_PRIME,  3'd3, 10'd923,  1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd3, 10'd923,  1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd3, 10'd915,  1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd3, 10'd907,  1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		// mean just under full scale snaps up
		'{MODE_PRIME,  3'd4, 10'd1,    1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd4, 10'd1,    1'b0, 1'b1, 1'b1, 3'd4, 10'd1023},
		// spike, full lap of the ring, then mean of one snaps to zero
		'{MODE_PRIME,  3'd6, 10'd1022, 1'b0, 1'b1, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd966,  1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b0, 1'b0, 3'd0, 10'd0},
		'{MODE_UPDATE, 3'd6, 10'd1022, 1'b0, 1'b1, 1'b1, 3'd6, 10'd0}
	};

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// filter state as the checker sees it
	logic [VAL_W-1:0] ring_q   [CHANNELS][WINDOW];
	logic [SUM_W-1:0] sum_q    [CHANNELS];
	int               slot_q   [CHANNELS];
	logic [VAL_W-1:0] report_q [CHANNELS];
	bit               primed_q [CHANNELS];

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      cycle_count    = 0;
	bit      send_gaps      = 1'b1;
	bit      stall_gaps     = 1'b1;

	analog_moving_average_deadband dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// one filter step: ring update, rounded mean, deadband and end snapping
	function automatic bit filter_step(input item_t beat, output result_t change);
		int inv;
		int ch;
		int pos;
		int sum;
		int mean;
		int prior;
		int diff;
		change = '0;
		ch = int'(beat.channel);
		if (ch >= CHANNELS)
			return 1'b0;
		inv = (int'(beat.sample) > FULL_SCALE) ? 0 : FULL_SCALE - int'(beat.sample);
		if (beat.mode == MODE_PRIME) begin
			for (int k = 0; k < WINDOW; k++)
				ring_q[ch][k] = VAL_W'(inv);
			sum_q[ch]    = SUM_W'(inv * WINDOW);
			slot_q[ch]   = 0;
			report_q[ch] = '0;
			return 1'b0;
		end
		pos = (slot_q[ch] >= WINDOW) ? 0 : slot_q[ch];
		sum = int'(sum_q[ch]) - int'(ring_q[ch][pos]) + inv;
		ring_q[ch][pos] = VAL_W'(inv);
		sum_q[ch]       = SUM_W'(sum);
		slot_q[ch]      = (pos + 1 >= WINDOW) ? 0 : pos + 1;
		mean  = (2 * sum + WINDOW) / (2 * WINDOW);
		prior = int'(report_q[ch]);
		diff  = (mean > prior) ? mean - prior : prior - mean;
		if (diff <= 1)
			return 1'b0;
		if (mean < 2)
			mean = 0;
		if (mean > FULL_SCALE - 2)
			mean = FULL_SCALE;
		report_q[ch] = VAL_W'(mean);
		if (beat.suppress_event)
			return 1'b0;
		change.out_channel = CH_W'(ch);
		change.value       = VAL_W'(mean);
		return 1'b1;
	endfunction

	// drive one beat after an idle gap, then book what it should produce
	task automatic push_beat(input item_t beat, input int gap, input bit given,
			input bit fires, input result_t want);
		result_t predicted;
		bit      emits;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		do @(posedge clk); while (item_stall);
		if (beat.mode == MODE_PRIME)
			primed_q[beat.channel] = 1'b1;
		emits = filter_step(beat, predicted);
		if (given) begin
			if (fires)
				pending_results.push_back(want);
		end else if (emits) begin
			pending_results.push_back(predicted);
		end
	endtask

	// result side: random stall before each beat, with calm stretches
	initial begin : result_side
		int hold;
		int draws;
		draws = 0;
		@(posedge clk);
		forever begin
			if (draws % 40 == 0)
				stall_gaps = ($urandom_range(0, 2) != 0);
			draws++;
			hold = stall_gaps ? $urandom_range(0, 4) : 0;
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// compare each accepted result beat with the oldest expected change
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual ch %0d value %0d",
					$time, result.out_channel, result.value);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.out_channel !== want.out_channel) begin
					$display("%0t: out_channel mismatch: expected %0d, actual %0d",
						$time, want.out_channel, result.out_channel);
					mismatch_count++;
				end
				if (result.value !== want.value) begin
					$display("%0t: value mismatch on ch %0d: expected %0d, actual %0d",
						$time, want.out_channel, want.value, result.value);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_analog_moving_average_deadband: done, errors");
			$finish;
		end
	end

	// stimulus: directed plan, then random bursts per channel
	initial begin : stimulus
		item_t beat;
		int    sent;
		int    ch;
		int    burst;
		int    flavor;
		int    level;
		int    raw;
		for (int c = 0; c < CHANNELS; c++) begin
			sum_q[c]    = '0;
			slot_q[c]   = 0;
			report_q[c] = '0;
			primed_q[c] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			beat.mode           = PLAN[r].mode;
			beat.channel        = PLAN[r].channel;
			beat.sample         = PLAN[r].sample;
			beat.suppress_event = PLAN[r].quiet;
			push_beat(beat, $urandom_range(0, 4), PLAN[r].given, PLAN[r].fires,
				'{PLAN[r].want_channel, PLAN[r].want_value});
		end

		// bursts on one channel keep its ring turning; flavor shapes the samples
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			ch     = $urandom_range(0, CHANNELS - 1);
			burst  = $urandom_range(1, 12);
			flavor = $urandom_range(0, 3);
			level  = $urandom_range(0, FULL_SCALE);
			for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
				if (sent % 50 == 0)
					send_gaps = ($urandom_range(0, 3) != 0);
				case (flavor)
					0: raw = $urandom_range(0, FULL_SCALE);
					1: raw = $urandom_range(0, 3);
					2: raw = $urandom_range(FULL_SCALE - 3, FULL_SCALE);
					default: begin
						raw = level + $urandom_range(0, 6) - 3;
						if (raw < 0)
							raw = 0;
						if (raw > FULL_SCALE)
							raw = FULL_SCALE;
					end
				endcase
				beat.channel        = CH_W'(ch);
				beat.sample         = VAL_W'(raw);
				beat.suppress_event = ($urandom_range(0, 4) == 0);
				if (!primed_q[ch] || $urandom_range(0, 19) == 0)
					beat.mode = MODE_PRIME;
				else
					beat.mode = MODE_UPDATE;
				push_beat(beat, send_gaps ? $urandom_range(0, 4) : 0, 1'b0, 1'b0, '0);
				sent++;
			end
		end
		item_valid <= 1'b0;

		// drain
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_analog_moving_average_deadband: done, clean");
		else
			$display("tb_analog_moving_average_deadband: done, errors");
		$finish;
	end

endmodule
